>>> rtl/core/tsla_pkg.sv
// Shared types and constants for the text stream line annotator.
package tsla_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUMBER_MODE      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SQUEEZE_BLANK    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHOW_TABS        = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHOW_ENDS        = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHOW_NONPRINTING = 3'd4;

   localparam logic [1:0] NUM_MODE_ALL      = 2'd1;
   localparam logic [1:0] NUM_MODE_NONBLANK = 2'd2;

   localparam logic [7:0] CHAR_TAB      = 8'd9;
   localparam logic [7:0] CHAR_NL       = 8'd10;
   localparam logic [7:0] CHAR_SPACE    = 8'd32;
   localparam logic [7:0] CHAR_DOLLAR   = 8'd36;
   localparam logic [7:0] CHAR_ZERO     = 8'd48;
   localparam logic [7:0] CHAR_I        = 8'd73;
   localparam logic [7:0] CHAR_CARET    = 8'd94;
   localparam logic [7:0] CARET_OFFSET  = 8'd64;
   localparam logic [7:0] PRINT_MAX     = 8'd126;
   localparam logic [7:0] HIGH_CTRL_MAX = 8'd160;

   typedef struct packed {
      logic [1:0] number_mode;
      logic       squeeze_blank;
      logic       show_tabs;
      logic       show_ends;
      logic       show_nonprinting;
   } cfg_type;

   // One queued item: optional lead field (number or pad), optional prefix, final byte.
   typedef struct packed {
      logic       lead_valid;
      logic       pre_valid;
      logic [7:0] pre_byte;
      logic [7:0] data_byte;
   } entry_type;

   typedef enum logic [1:0] {
      BK_START,
      BK_LEAD,
      BK_PRE,
      BK_BYTE
   } bk_phase_type;

endpackage

>>> rtl/core/tsla_front.sv
// Front end: accepts input beats, keeps line state and classifies each byte.
module tsla_front #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tsla_pkg::cfg_type        cfg,
   input  logic                     req_valid,
   input  logic [7:0]               req_byte,
   input  logic                     req_file_start,
   input  logic                     queue_full,
   output logic                     req_ready,
   output logic                     push,
   output tsla_pkg::entry_type      push_entry,
   output logic [NUMBER_DIGITS*8-1:0] push_chars
);

   localparam int DW = NUMBER_DIGITS * 4;
   localparam logic [DW-1:0] DIGITS_ONE = {{(DW-1){1'b0}}, 1'b1};

   logic [DW-1:0] digits_ff, digits_in;
   logic [1:0]    blank_run_ff, blank_run_in;
   logic          prev_nl_ff, prev_nl_in;

   logic [DW-1:0] eff_digits, inc_digits;
   logic [1:0]    eff_run;
   logic          eff_prev;
   logic          accept, is_nl, sq_hit, drop;
   logic          all_mode, nb_mode, do_num, pad;
   logic          tab_hit, dollar_hit, np_hit;
   logic [7:0]    c_tab, c_final;
   logic          leading;

   // Saturating BCD increment
   function automatic logic [DW-1:0] bcd_inc(input logic [DW-1:0] v);
      logic [DW-1:0] r;
      logic          carry;
      logic          all_nine;
      r        = v;
      carry    = 1'b1;
      all_nine = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (v[4*i +: 4] != 4'd9) all_nine = 1'b0;
      end
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (carry) begin
            if (v[4*i +: 4] >= 4'd9) begin
               r[4*i +: 4] = 4'd0;
            end else begin
               r[4*i +: 4] = v[4*i +: 4] + 4'd1;
               carry       = 1'b0;
            end
         end
      end
      return all_nine ? v : r;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      eff_digits = req_file_start ? DIGITS_ONE : digits_ff;
      eff_run    = req_file_start ? 2'd0 : blank_run_ff;
      eff_prev   = req_file_start ? 1'b1 : prev_nl_ff;
      is_nl      = (req_byte == tsla_pkg::CHAR_NL);
      all_mode   = (cfg.number_mode == tsla_pkg::NUM_MODE_ALL);
      nb_mode    = (cfg.number_mode == tsla_pkg::NUM_MODE_NONBLANK);

      sq_hit = cfg.squeeze_blank && is_nl && eff_prev;
      if (!sq_hit) begin
         blank_run_in = 2'd0;
      end else if (eff_run < 2'd2) begin
         blank_run_in = eff_run + 2'd1;
      end else begin
         blank_run_in = eff_run;
      end
      drop = sq_hit && (blank_run_in == 2'd2);

      do_num     = eff_prev && ((nb_mode && !is_nl) || all_mode);
      pad        = cfg.show_ends && is_nl && nb_mode && eff_prev;
      inc_digits = bcd_inc(eff_digits);

      tab_hit    = cfg.show_tabs && (req_byte == tsla_pkg::CHAR_TAB);
      c_tab      = tab_hit ? tsla_pkg::CHAR_I : req_byte;
      dollar_hit = cfg.show_ends && is_nl;
      np_hit     = cfg.show_nonprinting &&
                   ((c_tab < tsla_pkg::CHAR_TAB) ||
                    (c_tab > tsla_pkg::CHAR_NL && c_tab < tsla_pkg::CHAR_SPACE) ||
                    (c_tab > tsla_pkg::PRINT_MAX && c_tab <= tsla_pkg::HIGH_CTRL_MAX));
      if (!np_hit) begin
         c_final = c_tab;
      end else if (c_tab > tsla_pkg::PRINT_MAX) begin
         c_final = c_tab - tsla_pkg::CARET_OFFSET;
      end else begin
         c_final = c_tab + tsla_pkg::CARET_OFFSET;
      end

      // Lead characters in send order, most significant digit first
      leading = 1'b1;
      for (int k = 0; k < NUMBER_DIGITS; k++) begin
         if (eff_digits[4*(NUMBER_DIGITS-1-k) +: 4] != 4'd0 || k == NUMBER_DIGITS-1)
            leading = 1'b0;
         if (pad || leading) begin
            push_chars[8*k +: 8] = tsla_pkg::CHAR_SPACE;
         end else begin
            push_chars[8*k +: 8] = tsla_pkg::CHAR_ZERO |
                                   {4'd0, eff_digits[4*(NUMBER_DIGITS-1-k) +: 4]};
         end
      end

      push_entry.lead_valid = do_num || pad;
      push_entry.pre_valid  = tab_hit || dollar_hit || np_hit;
      push_entry.pre_byte   = dollar_hit ? tsla_pkg::CHAR_DOLLAR : tsla_pkg::CHAR_CARET;
      push_entry.data_byte  = c_final;

      push = accept && !drop;

      if (drop) begin
         digits_in  = eff_digits;
         prev_nl_in = eff_prev;
      end else begin
         digits_in  = do_num ? inc_digits : eff_digits;
         prev_nl_in = is_nl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff    <= DIGITS_ONE;
         blank_run_ff <= 2'd0;
         prev_nl_ff   <= 1'b1;
      end else if (accept) begin
         digits_ff    <= digits_in;
         blank_run_ff <= blank_run_in;
         prev_nl_ff   <= prev_nl_in;
      end
   end

   // A dropped blank line leaves the run count at its ceiling
   assert property (@(posedge clock) disable iff (reset)
      accept && drop |=> blank_run_ff == 2'd2)
      else $error("blank run not saturated after drop");

endmodule

>>> rtl/core/tsla_queue.sv
// Short FIFO of classified items between front and back.
module tsla_queue #(
   parameter int NUMBER_DIGITS = 6,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tsla_pkg::entry_type        push_entry,
   input  logic [NUMBER_DIGITS*8-1:0] push_chars,
   input  logic                       pop,
   output logic                       full,
   output logic                       head_valid,
   output tsla_pkg::entry_type        head_entry,
   output logic [NUMBER_DIGITS*8-1:0] head_chars
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   tsla_pkg::entry_type              entries_ff [QUEUE_DEPTH];
   logic [NUMBER_DIGITS*8-1:0]       chars_ff   [QUEUE_DEPTH];
   logic [PW-1:0]                    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]                    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]                    count_ff, count_in;

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign head_chars = chars_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
         chars_ff[wr_ptr_ff]   <= push_chars;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue overflow");

   assert property (@(posedge clock) disable iff (reset) !(pop && !head_valid))
      else $error("queue underflow");

endmodule

>>> rtl/core/tsla_back.sv
// Back end: expands the head item into output beats through an output register.
module tsla_back #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  tsla_pkg::entry_type        head_entry,
   input  logic [NUMBER_DIGITS*8-1:0] head_chars,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int IW = $clog2(NUMBER_DIGITS + 1);

   tsla_pkg::bk_phase_type phase_ff, phase_in, cur_phase;
   logic [IW-1:0]          idx_ff, idx_in, cur_idx;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]             rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tlast_ff, rsp_tlast_in;
   logic                   advance;
   logic [7:0]             lead_byte;

   assign advance = head_valid && (!rsp_tvalid_ff || rsp_tready);

   // At the start of an item, skip straight to its first present part
   always_comb begin
      if (phase_ff == tsla_pkg::BK_START) begin
         cur_idx = '0;
         if (head_entry.lead_valid) begin
            cur_phase = tsla_pkg::BK_LEAD;
         end else if (head_entry.pre_valid) begin
            cur_phase = tsla_pkg::BK_PRE;
         end else begin
            cur_phase = tsla_pkg::BK_BYTE;
         end
      end else begin
         cur_phase = phase_ff;
         cur_idx   = idx_ff;
      end
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (advance) begin
         unique case (cur_phase)
            tsla_pkg::BK_LEAD: begin
               if (cur_idx == IW'(NUMBER_DIGITS)) begin
                  phase_in = head_entry.pre_valid ? tsla_pkg::BK_PRE : tsla_pkg::BK_BYTE;
                  idx_in   = '0;
               end else begin
                  phase_in = tsla_pkg::BK_LEAD;
                  idx_in   = cur_idx + IW'(1);
               end
            end
            tsla_pkg::BK_PRE:  phase_in = tsla_pkg::BK_BYTE;
            tsla_pkg::BK_BYTE: begin
               phase_in = tsla_pkg::BK_START;
               idx_in   = '0;
            end
            default:           phase_in = tsla_pkg::BK_START;
         endcase
      end
   end

   // Outputs
   always_comb begin
      lead_byte = tsla_pkg::CHAR_TAB;
      for (int k = 0; k < NUMBER_DIGITS; k++) begin
         if (cur_idx == IW'(k)) lead_byte = head_chars[8*k +: 8];
      end

      pop           = 1'b0;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      if (advance) begin
         rsp_tvalid_in = 1'b1;
         rsp_tlast_in  = 1'b0;
         unique case (cur_phase)
            tsla_pkg::BK_LEAD: rsp_tdata_in = lead_byte;
            tsla_pkg::BK_PRE:  rsp_tdata_in = head_entry.pre_byte;
            tsla_pkg::BK_BYTE: begin
               rsp_tdata_in = head_entry.data_byte;
               rsp_tlast_in = 1'b1;
               pop          = 1'b1;
            end
            default:           rsp_tdata_in = head_entry.data_byte;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tsla_pkg::BK_START;
         idx_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // An item in progress stays at the queue head until its final beat
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != tsla_pkg::BK_START |-> head_valid)
      else $error("item in progress lost from queue head");

   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_tvalid && rsp_tlast)
      else $error("final beat not marked last");

endmodule

>>> rtl/core/text_stream_line_annotator.sv
// Top level of the text stream line annotator: control registers, front, queue, back.
//
// Each input beat carries one text byte and yields zero to NUMBER_DIGITS+3 output
// beats, the last one flagged by rsp_tlast. The front end takes one input beat per
// cycle while the item queue (QUEUE_DEPTH entries) has room; the back end sends
// one output byte per cycle while rsp_tready is high. An item has one output byte
// for most bytes, two for caret or '$' forms, and up to NUMBER_DIGITS+3 at a
// numbered or padded line start. Input beats that only add to the queue are taken
// while earlier output is still draining. Control registers are written with
// csr_we/csr_addr/csr_wdata and should only change while the block is idle.
module text_stream_line_annotator #(
   parameter int NUMBER_DIGITS = 6,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [tsla_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [tsla_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] in_byte
   input  logic                              req_tuser,   // [0] file_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] out_byte
   output logic                              rsp_tlast
);

   tsla_pkg::cfg_type          cfg_ff, cfg_in;
   logic                       queue_full, push, pop, head_valid;
   tsla_pkg::entry_type        push_entry, head_entry;
   logic [NUMBER_DIGITS*8-1:0] push_chars, head_chars;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            tsla_pkg::CSR_NUMBER_MODE:      cfg_in.number_mode      = csr_wdata;
            tsla_pkg::CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_wdata[0];
            tsla_pkg::CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_wdata[0];
            tsla_pkg::CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_wdata[0];
            tsla_pkg::CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_wdata[0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsla_front #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_tvalid),
      .req_byte       (req_tdata),
      .req_file_start (req_tuser),
      .queue_full     (queue_full),
      .req_ready      (req_tready),
      .push           (push),
      .push_entry     (push_entry),
      .push_chars     (push_chars)
   );

   tsla_queue #(
      .NUMBER_DIGITS (NUMBER_DIGITS),
      .QUEUE_DEPTH   (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_chars (push_chars),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_chars (head_chars)
   );

   tsla_back #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_chars (head_chars),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
